// File: design/cprg_pkg.sv
// ----------------------------------------------------------------------------
// cprg_pkg
// Types and constants shared by the primary ray generator: item structs,
// register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package cprg_pkg;

   // limits on the frame size
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // fixed-point formats
   localparam int FRAC_BITS = 14;
   localparam int NORM_BITS = 20;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORWARD_BASIS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UP_BASIS      = 3'd4;

   localparam logic [12:0] FRAME_WIDTH_RST   = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST  = 13'd480;
   localparam logic [23:0] PIXEL_SCALE_RST   = 24'd52429;
   localparam logic [47:0] FORWARD_BASIS_RST = 48'h4000_0000_0000;
   localparam logic [47:0] UP_BASIS_RST      = 48'h0000_4000_0000;

   // datapath widths
   localparam int SIZE_BITS  = 13;
   localparam int MAG_BITS   = 28;
   localparam int SQ_BITS    = 58;
   localparam int ROOT_STEPS = 29;
   localparam int QUOT_BITS  = NORM_BITS + 1;
   localparam int DIR_BITS   = NORM_BITS + 2;
   localparam int RIGHT_BITS = 33 - FRAC_BITS;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsp_type;

   // values that ride along with the square root
   typedef struct packed {
      logic                sign_x;
      logic                sign_y;
      logic [MAG_BITS-1:0] mag_x;
      logic [MAG_BITS-1:0] mag_y;
   } carry_type;

   // one division lane: partial remainder and dividend bits turning into quotient
   typedef struct packed {
      logic [ROOT_STEPS-1:0] rem;
      logic [QUOT_BITS-1:0]  low;
   } lane_type;

endpackage

// File: design/camera_primary_ray_generator_unit.sv
// ----------------------------------------------------------------------------
// camera_primary_ray_generator_unit
// Pinhole camera primary ray generation: pixel coordinate in, unit world
// direction in Q2.14 out.
//
// Usage:
//   An item (pixel_x, pixel_y) is taken at a clock edge with start high and
//   busy low. busy is high only during reset, so an item may enter every
//   cycle. Each item gives one result on rsp_item, marked by rsp_strobe for
//   one cycle, in order. The receiver cannot hold results off and the
//   pipeline never stalls. The pipeline holds the 29 stages of the square
//   root (one root bit per stage) and the 21 stages of the divider (one
//   quotient bit per stage), plus nine stages of offset, scale, square,
//   rotate and round logic. Registers are written through csr_valid /
//   csr_ready; the user must write them only while no item is in flight,
//   which the block itself does not enforce. csr_ready is high outside reset.
//   Reset clears all valid bits and loads the register reset values
//   (640 x 480 frame, forward +z, up +y).
// ----------------------------------------------------------------------------
module camera_primary_ray_generator_unit #(
   parameter int MAX_WIDTH  = cprg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cprg_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cprg_pkg::req_type                   req_item,
   output logic                                rsp_strobe,
   output cprg_pkg::rsp_type                   rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cprg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cprg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cprg_pkg::*;

   localparam int SIZE_TOP = (1 << SIZE_BITS) - 1;
   localparam logic [SIZE_BITS-1:0] WIDTH_CAP =
      SIZE_BITS'((MAX_WIDTH > SIZE_TOP) ? SIZE_TOP : MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] HEIGHT_CAP =
      SIZE_BITS'((MAX_HEIGHT > SIZE_TOP) ? SIZE_TOP : MAX_HEIGHT);
   localparam int LATENCY = 5 + ROOT_STEPS + 1 + QUOT_BITS + 3;

   // configuration registers
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [23:0]          scale_ff;
   logic [47:0]          fwd_ff, up_ff;

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
         scale_ff  <= PIXEL_SCALE_RST;
         fwd_ff    <= FORWARD_BASIS_RST;
         up_ff     <= UP_BASIS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT:  height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_PIXEL_SCALE:   scale_ff  <= csr_wdata[23:0];
            CSR_FORWARD_BASIS: fwd_ff    <= csr_wdata;
            CSR_UP_BASIS:      up_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // right = up x forward, kept up to date from the basis registers
   logic signed [15:0] f_c [3];
   logic signed [15:0] u_c [3];
   logic signed [31:0] cp_ff [6];
   logic signed [RIGHT_BITS-1:0] right_ff [3];
   logic signed [RIGHT_BITS-1:0] right_in [3];
   logic signed [32:0] cross_d [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_c[i] = $signed(fwd_ff[16*i +: 16]);
         u_c[i] = $signed(up_ff[16*i +: 16]);
      end
      cross_d[0] = 33'(cp_ff[0]) - 33'(cp_ff[1]);
      cross_d[1] = 33'(cp_ff[2]) - 33'(cp_ff[3]);
      cross_d[2] = 33'(cp_ff[4]) - 33'(cp_ff[5]);
      for (int i = 0; i < 3; i++) begin
         right_in[i] = RIGHT_BITS'((cross_d[i] + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      cp_ff[0] <= u_c[1] * f_c[2];
      cp_ff[1] <= u_c[2] * f_c[1];
      cp_ff[2] <= u_c[2] * f_c[0];
      cp_ff[3] <= u_c[0] * f_c[2];
      cp_ff[4] <= u_c[0] * f_c[1];
      cp_ff[5] <= u_c[1] * f_c[0];
      right_ff <= right_in;
   end

   // stage 1: doubled pixel offsets from the frame center
   logic [SIZE_BITS-1:0] wsat, hsat;
   logic signed [13:0]   tx_in, ty_in, tx_ff, ty_ff;
   logic                 v1_ff;

   always_comb begin
      wsat  = (width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff;
      hsat  = (height_ff > HEIGHT_CAP) ? HEIGHT_CAP : height_ff;
      tx_in = $signed({1'b0, req_item.pixel_x, 1'b1})
            - $signed({1'b0, wsat[SIZE_BITS-1:1], 1'b0});
      ty_in = $signed({1'b0, req_item.pixel_y, 1'b1})
            - $signed({1'b0, hsat[SIZE_BITS-1:1], 1'b0});
   end

   // stage 2: scale
   logic signed [38:0] px_ff, py_ff;
   logic               v2_ff;

   // stage 3: camera-space components as sign and magnitude
   logic signed [38:0] rx, ry;
   logic signed [28:0] vx, vy;
   carry_type          c3_in, c3_ff;
   logic               v3_ff;

   always_comb begin
      rx = px_ff + 39'sd256;
      ry = py_ff + 39'sd256;
      vx = rx[37:9];
      vy = ry[37:9];
      c3_in.sign_x = vx[28];
      c3_in.sign_y = vy[28];
      c3_in.mag_x  = vx[28] ? MAG_BITS'(-vx) : MAG_BITS'(vx);
      c3_in.mag_y  = vy[28] ? MAG_BITS'(-vy) : MAG_BITS'(vy);
   end

   // stage 4: squares
   logic [2*MAG_BITS-1:0] sqx_ff, sqy_ff;
   carry_type             c4_ff;
   logic                  v4_ff;

   // square root pipeline, element 0 holds the squared length
   logic [SQ_BITS-1:0] sq_n_ff    [0:ROOT_STEPS];
   logic [SQ_BITS-1:0] sq_root_ff [0:ROOT_STEPS];
   carry_type          sq_c_ff    [0:ROOT_STEPS];
   logic               sq_v_ff    [0:ROOT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else begin
         v1_ff      <= start && !busy;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         sq_v_ff[0] <= v4_ff;
      end
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      px_ff         <= tx_ff * $signed({1'b0, scale_ff});
      py_ff         <= ty_ff * $signed({1'b0, scale_ff});
      c3_ff         <= c3_in;
      sqx_ff        <= c3_ff.mag_x * c3_ff.mag_x;
      sqy_ff        <= c3_ff.mag_y * c3_ff.mag_y;
      c4_ff         <= c3_ff;
      sq_n_ff[0]    <= SQ_BITS'(sqx_ff) + SQ_BITS'(sqy_ff) + (SQ_BITS'(1) << 32);
      sq_root_ff[0] <= '0;
      sq_c_ff[0]    <= c4_ff;
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [SQ_BITS-1:0] trial, n_in, root_in;
      logic               ge;

      always_comb begin
         trial   = sq_root_ff[k] + BIT;
         ge      = sq_n_ff[k] >= trial;
         n_in    = ge ? sq_n_ff[k] - trial : sq_n_ff[k];
         root_in = ge ? (sq_root_ff[k] >> 1) + BIT : sq_root_ff[k] >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         sq_n_ff[k+1]    <= n_in;
         sq_root_ff[k+1] <= root_in;
         sq_c_ff[k+1]    <= sq_c_ff[k];
      end
   end

   // divider pipeline, element 0 holds the rounded dividends
   logic [ROOT_STEPS-1:0] len;
   logic [48:0]           num [3];
   lane_type              ln_in [3];
   lane_type              dv_ln_ff  [0:QUOT_BITS][3];
   logic [ROOT_STEPS-1:0] dv_len_ff [0:QUOT_BITS];
   logic [1:0]            dv_sg_ff  [0:QUOT_BITS];
   logic                  dv_v_ff   [0:QUOT_BITS];

   always_comb begin
      len    = sq_root_ff[ROOT_STEPS][ROOT_STEPS-1:0];
      num[0] = {1'b0, sq_c_ff[ROOT_STEPS].mag_x, {NORM_BITS{1'b0}}} + 49'(len >> 1);
      num[1] = {1'b0, sq_c_ff[ROOT_STEPS].mag_y, {NORM_BITS{1'b0}}} + 49'(len >> 1);
      num[2] = (49'd1 << (16 + NORM_BITS)) + 49'(len >> 1);
      for (int i = 0; i < 3; i++) begin
         ln_in[i].rem = ROOT_STEPS'(num[i][48:QUOT_BITS]);
         ln_in[i].low = num[i][QUOT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sq_v_ff[ROOT_STEPS];
      end
      dv_ln_ff[0]  <= ln_in;
      dv_len_ff[0] <= len;
      dv_sg_ff[0]  <= {sq_c_ff[ROOT_STEPS].sign_y, sq_c_ff[ROOT_STEPS].sign_x};
   end

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
      lane_type          step_in [3];
      logic [ROOT_STEPS:0] t [3];
      logic                ge [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i]  = {dv_ln_ff[j][i].rem, dv_ln_ff[j][i].low[QUOT_BITS-1]};
            ge[i] = t[i] >= {1'b0, dv_len_ff[j]};
            step_in[i].rem = ge[i] ? ROOT_STEPS'(t[i] - {1'b0, dv_len_ff[j]})
                                   : t[i][ROOT_STEPS-1:0];
            step_in[i].low = {dv_ln_ff[j][i].low[QUOT_BITS-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
         dv_ln_ff[j+1]  <= step_in;
         dv_len_ff[j+1] <= dv_len_ff[j];
         dv_sg_ff[j+1]  <= dv_sg_ff[j];
      end
   end

   // signed normalized camera vector
   logic signed [DIR_BITS-1:0] q_s [3];
   logic signed [DIR_BITS-1:0] n_in [3];
   logic signed [DIR_BITS-1:0] n_ff [3];
   logic                       vn_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_s[i] = $signed({1'b0, dv_ln_ff[QUOT_BITS][i].low});
      end
      n_in[0] = dv_sg_ff[QUOT_BITS][0] ? -q_s[0] : q_s[0];
      n_in[1] = dv_sg_ff[QUOT_BITS][1] ? -q_s[1] : q_s[1];
      n_in[2] = q_s[2];
   end

   // rotation products
   localparam int PROD_BITS = RIGHT_BITS + DIR_BITS;
   localparam int ACC_BITS  = PROD_BITS + 2;
   logic signed [PROD_BITS-1:0] pr_ff [3];
   logic signed [PROD_BITS-1:0] pu_ff [3];
   logic signed [PROD_BITS-1:0] pf_ff [3];
   logic                        vp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff      <= 1'b0;
         vp_ff      <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         vn_ff      <= dv_v_ff[QUOT_BITS];
         vp_ff      <= vn_ff;
         rsp_strobe <= vp_ff;
      end
      n_ff <= n_in;
      for (int i = 0; i < 3; i++) begin
         pr_ff[i] <= PROD_BITS'(right_ff[i] * n_ff[0]);
         pu_ff[i] <= PROD_BITS'(u_c[i] * n_ff[1]);
         pf_ff[i] <= PROD_BITS'(f_c[i] * n_ff[2]);
      end
   end

   // dot sums, rounding and saturation
   logic signed [ACC_BITS-1:0] acc [3];
   logic signed [ACC_BITS-1:0] rnd [3];
   logic signed [15:0]         sat [3];
   rsp_type                    out_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_BITS'(pr_ff[i]) + ACC_BITS'(pu_ff[i]) + ACC_BITS'(pf_ff[i]);
         rnd[i] = (acc[i] + (ACC_BITS'(1) <<< (NORM_BITS - 1))) >>> NORM_BITS;
         if (rnd[i] > ACC_BITS'(32767)) begin
            sat[i] = 16'sh7FFF;
         end else if (rnd[i] < -ACC_BITS'(32768)) begin
            sat[i] = -16'sh8000;
         end else begin
            sat[i] = rnd[i][15:0];
         end
      end
      out_in.dir_x = sat[0];
      out_in.dir_y = sat[1];
      out_in.dir_z = sat[2];
   end

   always_ff @(posedge clock) begin
      rsp_item <= out_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("item result missing at fixed latency");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[ROOT_STEPS] |-> (sq_root_ff[ROOT_STEPS] >= (SQ_BITS'(1) << 16)) &&
                              (sq_root_ff[ROOT_STEPS] < (SQ_BITS'(1) << ROOT_STEPS)))
      else $error("square root out of range");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[QUOT_BITS] |->
         (dv_ln_ff[QUOT_BITS][0].low <= (QUOT_BITS'(1) << NORM_BITS)) &&
         (dv_ln_ff[QUOT_BITS][1].low <= (QUOT_BITS'(1) << NORM_BITS)) &&
         (dv_ln_ff[QUOT_BITS][2].low <= (QUOT_BITS'(1) << NORM_BITS)))
      else $error("normalized component above one");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for camera_primary_ray_generator_unit. Pixel items go in through
// the start / busy port, in bursts with random gaps. An in-house model works
// out each expected ray direction, and a checker compares every strobed
// result with the oldest waiting expectation. The runs cover register
// settings at their extremes, frame corners, pixels outside the frame and
// odd-shaped bases.
// ----------------------------------------------------------------------------
module tb_top;
   import cprg_pkg::*;

   // index past the register list
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_type         req_item = '0;
   logic            rsp_strobe;
   rsp_type         rsp_item;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [2:0]      csr_index = '0;
   logic [47:0]     csr_wdata = '0;

   logic [12:0]     mdl_width;
   logic [12:0]     mdl_height;
   logic [23:0]     mdl_scale;
   logic [47:0]     mdl_forward;
   logic [47:0]     mdl_up;

   rsp_type         pending_dirs[$];
   int              error_count = 0;
   int              checked_count = 0;
   int              sent_count = 0;
   longint          cycle_count = 0;
   int              burst_left = 0;

   camera_primary_ray_generator_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint basis_part(logic [47:0] packed_v, int i);
      logic signed [15:0] c;
      c = packed_v[16*i +: 16];
      return longint'(c);
   endfunction

   function automatic longint cam_offset(logic [11:0] pos, logic [12:0] size, int max_size);
      longint s;
      longint twice;
      s = (size > max_size) ? max_size : size;
      twice = 2 * longint'(pos) - 2 * (s >> 1) + 1;
      return rnd_shift(twice * longint'(mdl_scale), 9);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint scaled_div(longint v, longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : v;
      q = ((mag << NORM_BITS) + (d >> 1)) / d;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic rsp_type ray_direction(req_type px);
      longint vx, vy, acc;
      longint unsigned ax, ay, len;
      longint n[3], f[3], u[3], r[3];
      logic [15:0] d[3];
      rsp_type res;
      vx = cam_offset(px.pixel_x, mdl_width, MAX_WIDTH_DEF);
      vy = cam_offset(px.pixel_y, mdl_height, MAX_HEIGHT_DEF);
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      len = int_sqrt(ax * ax + ay * ay + (64'd1 << 32));
      n[0] = scaled_div(vx, len);
      n[1] = scaled_div(vy, len);
      n[2] = longint'(((64'd1 << (16 + NORM_BITS)) + (len >> 1)) / len);
      for (int i = 0; i < 3; i++) begin
         f[i] = basis_part(mdl_forward, i);
         u[i] = basis_part(mdl_up, i);
      end
      r[0] = rnd_shift(u[1] * f[2] - u[2] * f[1], FRAC_BITS);
      r[1] = rnd_shift(u[2] * f[0] - u[0] * f[2], FRAC_BITS);
      r[2] = rnd_shift(u[0] * f[1] - u[1] * f[0], FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         acc = r[i] * n[0] + u[i] * n[1] + f[i] * n[2];
         d[i] = clamp16(rnd_shift(acc, NORM_BITS));
      end
      res.dir_x = d[0];
      res.dir_y = d[1];
      res.dir_z = d[2];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_dirs.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_dirs.pop_front();
            checked_count++;
            if (rsp_item.dir_x !== want.dir_x) report_mismatch("dir_x", rsp_item.dir_x, want.dir_x);
            if (rsp_item.dir_y !== want.dir_y) report_mismatch("dir_y", rsp_item.dir_y, want.dir_y);
            if (rsp_item.dir_z !== want.dir_z) report_mismatch("dir_z", rsp_item.dir_z, want.dir_z);
         end
      end
   end

   task automatic send_pixel(logic [11:0] x, logic [11:0] y);
      req_type px;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = int'($urandom_range(1, 40));
      end
      burst_left--;
      px.pixel_x = x;
      px.pixel_y = y;
      start <= 1'b1;
      req_item <= px;
      do @(posedge clock); while (busy);
      pending_dirs.push_back(ray_direction(px));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      burst_left = 0;
      while (pending_dirs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH:   mdl_width = value[12:0];
         CSR_FRAME_HEIGHT:  mdl_height = value[12:0];
         CSR_PIXEL_SCALE:   mdl_scale = value[23:0];
         CSR_FORWARD_BASIS: mdl_forward = value;
         CSR_UP_BASIS:      mdl_up = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic setup_frame(int w, int h, int scale, logic [47:0] fwd, logic [47:0] up);
      write_reg(CSR_FRAME_WIDTH, 48'(w));
      write_reg(CSR_FRAME_HEIGHT, 48'(h));
      write_reg(CSR_PIXEL_SCALE, 48'(scale));
      write_reg(CSR_FORWARD_BASIS, fwd);
      write_reg(CSR_UP_BASIS, up);
   endtask

   function automatic logic [47:0] rand_basis();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_reset_corners;
      send_pixel(0, 0);
      send_pixel(639, 479);
      send_pixel(320, 240);
      send_pixel(319, 239);
      send_pixel(4095, 4095);
      send_pixel(12'hAAA, 12'h555);
      drain();
   endtask

   task automatic test_extreme_registers;
      setup_frame(4096, 4096, 24'hFFFFFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2048, 0);
      drain();
      // odd, tiny and oversize frames
      setup_frame(8191, 1, 1, 48'h0, 48'h0);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      drain();
      setup_frame(0, 7, 24'h000400, FORWARD_BASIS_RST, UP_BASIS_RST);
      send_pixel(1, 3);
      send_pixel(12'h555, 12'hAAA);
      drain();
      write_reg(CSR_SPARE_INDEX, 48'hFFFF_FFFF_FFFF);
      setup_frame(2, 2, 24'h800000, 48'h0000_0000_C000, 48'h0000_4000_0000);
      send_pixel(0, 0);
      send_pixel(1, 1);
      drain();
   endtask

   task automatic test_random_frames;
      int w, h;
      for (int phase = 0; phase < 8; phase++) begin
         w = (phase % 3 == 0) ? int'($urandom_range(0, 8191))
                              : 2 * int'($urandom_range(1, 2048));
         h = (phase % 3 == 1) ? int'($urandom_range(0, 8191))
                              : 2 * int'($urandom_range(1, 2048));
         setup_frame(w, h, (phase < 2) ? int'($urandom_range(1, 24'hFFFFFF))
                                      : int'($urandom_range(1, 200000)),
                     (phase % 2) ? rand_basis() : FORWARD_BASIS_RST,
                     (phase % 2) ? rand_basis() : UP_BASIS_RST);
         for (int k = 0; k < 130; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            else
               send_pixel(12'($urandom_range(0, (w > 4096 ? 4096 : (w < 1 ? 1 : w)) - 1)),
                          12'($urandom_range(0, (h > 4096 ? 4096 : (h < 1 ? 1 : h)) - 1)));
         end
         drain();
      end
   endtask

   initial begin
      mdl_width = FRAME_WIDTH_RST;
      mdl_height = FRAME_HEIGHT_RST;
      mdl_scale = PIXEL_SCALE_RST;
      mdl_forward = FORWARD_BASIS_RST;
      mdl_up = UP_BASIS_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_corners();
      test_extreme_registers();
      test_random_frames();
      drain();
      repeat (70) @(negedge clock);
      $display("sent %0d pixel items, checked %0d ray directions", sent_count, checked_count);
      $display("covered reset, extreme, odd and random frame settings");
      if (error_count == 0 && pending_dirs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/cprg_pkg.sv
design/camera_primary_ray_generator_unit.sv
tb/sv/tb_top.sv
